FILE: rtl/dbs_pkg.sv
// Shared command and status codes and the controller state type for the deque.
package dbs_pkg;

    // Command codes
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CHECK      = 3'd4
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

endpackage

FILE: rtl/dbs_ram.sv
// Entry store: one write port, one read port with registered read data.
module dbs_ram #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [31:0]                wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [31:0]                rd_data
);

    logic [31:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/bounded_deque_with_search.sv
// Bounded double-ended queue on a ring buffer, with a membership search.
//
//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------------------
//  request   | start, busy         | command[2:0], value[31:0]
//  result    | done (1-cycle strobe)| status[1:0], found, occupancy
//
// Push and pop requests never raise busy and their result strobes in the
// next cycle, so one such request may be issued every cycle.
// A check on a nonempty deque holds busy while it reads and compares the live
// entries in order through the entry memory's single read port, ending early when
// the value is found; the result strobes in the first cycle with busy low.
// Reset clears the state, front pointer, count and done; entry contents need no clearing.
// The result receiver cannot stall, so results are never held back.
module bounded_deque_with_search #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [2:0]                    command,
    input  logic signed [31:0]            value,
    output logic                          busy,
    output logic                          done,
    output logic [1:0]                    status,
    output logic                          found,
    output logic [$clog2(DEPTH+1)-1:0]    occupancy
);

    import dbs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t          state_reg, state_next;
    logic [AW-1:0]   front_reg, front_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            cmp_valid_reg, cmp_valid_next;
    logic            cmp_last_reg, cmp_last_next;
    logic [31:0]     key_reg, key_next;
    logic            done_reg, done_next;
    status_t         status_reg, status_next;
    logic            found_reg, found_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [31:0]     rd_data;
    logic            hit;
    logic            scan_end;
    logic            is_full;
    logic            is_empty;

    // Ring index add; both operands below DEPTH
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign hit      = (rd_data == key_reg);
    assign scan_end = cmp_valid_reg && (hit || cmp_last_reg);

    dbs_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && (cmd_t'(command) == CMD_CHECK) && !is_empty)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        busy  = 1'b0;
        rd_en = 1'b0;
        unique case (state_reg)
            S_IDLE: ;
            S_SCAN:
            begin
                busy  = 1'b1;
                rd_en = (idx_reg < count_reg);
            end
            default: ;
        endcase
    end

    // Scan read address: front plus entries issued so far
    assign rd_addr = slot_add(front_reg, idx_reg[AW-1:0]);

    // Datapath: pointer updates, writes, scan bookkeeping, result
    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        cmp_last_next  = 1'b0;
        key_next       = key_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        found_next     = found_reg;
        wr_en          = 1'b0;
        wr_addr        = front_reg;

        if (state_reg == S_IDLE)
        begin
            if (start)
            begin
                done_next   = 1'b1;
                status_next = ST_DONE;
                found_next  = 1'b0;
                unique case (cmd_t'(command))
                    CMD_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            front_next = (front_reg == '0) ? AW'(DEPTH - 1)
                                                           : front_reg - AW'(1);
                            wr_en      = 1'b1;
                            wr_addr    = front_next;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = slot_add(front_reg, count_reg[AW-1:0]);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            front_next = slot_add(front_reg, AW'(1));
                            count_next = count_reg - CW'(1);
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    CMD_CHECK:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            // result comes when the scan ends
                            done_next = 1'b0;
                            idx_next  = '0;
                            key_next  = value;
                        end
                    end
                    default: ;
                endcase
            end
        end
        else
        begin
            // issue one read per cycle, compare the returned data once the memory has registered it
            if (rd_en)
            begin
                idx_next       = idx_reg + CW'(1);
                cmp_valid_next = 1'b1;
                cmp_last_next  = ((idx_reg + CW'(1)) == count_reg);
            end
            if (scan_end)
            begin
                done_next      = 1'b1;
                status_next    = ST_DONE;
                found_next     = hit;
                cmp_valid_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cmp_last_reg <= cmp_last_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign occupancy = count_reg;

endmodule

FILE: rtl/dbs_checker.sv
// Port-level checker for the deque and its bind to the top level.
module dbs_checker #(
    parameter int DEPTH = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [2:0]                    command,
    input logic                          done,
    input logic [1:0]                    status,
    input logic                          found,
    input logic [$clog2(DEPTH+1)-1:0]    occupancy
);

    import dbs_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // A hit is only reported on a result with done status
    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == ST_DONE))
        else $error("found set on a result that is not a completed check");

    // Push, pop and unknown requests answer in the next cycle
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command != CMD_CHECK)) |=> done)
        else $error("non-check request did not answer next cycle");

    // A check either answers next cycle or starts scanning
    a_check_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_CHECK)) |=> (done || busy))
        else $error("check request neither answered nor started a scan");

    // Full is reported only at full occupancy
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (occupancy == CW'(DEPTH)))
        else $error("full status below full occupancy");

    // Occupancy moves only after an accepted request
    a_occ_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !($past(start) && !$past(busy)) |-> $stable(occupancy))
        else $error("occupancy changed without a request");

endmodule

bind bounded_deque_with_search dbs_checker #(
    .DEPTH (DEPTH)
) u_dbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .done      (done),
    .status    (status),
    .found     (found),
    .occupancy (occupancy)
);

FILE: test/bounded_deque_with_search_test.sv
// Self-checking testbench for the bounded deque with membership search.
module bounded_deque_with_search_test;
    import dbs_pkg::*;

    localparam int DEPTH = 64;
    localparam int OCC_W = $clog2(DEPTH + 1);

    // Spare command codes the block must treat as no-ops
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // Random stimulus mixes
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    // Expected outcome of one request
    typedef struct {
        status_t            status;
        logic               found;
        logic [OCC_W-1:0]   occupancy;
    } outcome_t;

    // Shadow deque plus the queue of outcomes still due from the block
    class deque_tracker;
        logic [31:0]  slots [DEPTH];
        logic [5:0]   front;
        int unsigned  count;
        outcome_t     awaited [$];
        int unsigned  mismatches;

        function new();
            front      = '0;
            count      = 0;
            mismatches = 0;
        endfunction

        // Apply one command to the shadow state and return what it should report
        function outcome_t apply_command(logic [2:0] cmd, logic [31:0] val);
            outcome_t r;
            r.status = ST_DONE;
            r.found  = 1'b0;
            case (cmd)
                CMD_PUSH_FRONT:
                    if (count >= DEPTH) r.status = ST_FULL;
                    else
                    begin
                        front        = front - 6'd1;
                        slots[front] = val;
                        count++;
                    end
                CMD_PUSH_BACK:
                    if (count >= DEPTH) r.status = ST_FULL;
                    else
                    begin
                        slots[front + 6'(count)] = val;
                        count++;
                    end
                CMD_POP_FRONT:
                    if (count == 0) r.status = ST_EMPTY;
                    else
                    begin
                        front = front + 6'd1;
                        count--;
                    end
                CMD_POP_BACK:
                    if (count == 0) r.status = ST_EMPTY;
                    else count--;
                CMD_CHECK:
                    if (count == 0) r.status = ST_EMPTY;
                    else
                    begin
                        for (int i = 0; i < count; i++)
                            if (slots[front + 6'(i)] == val) r.found = 1'b1;
                    end
                default: ;
            endcase
            r.occupancy = OCC_W'(count);
            return r;
        endfunction

        // An accepted request: predict and queue its outcome
        function void note_request(logic [2:0] cmd, logic [31:0] val);
            awaited.insert(awaited.size(), apply_command(cmd, val));
        endfunction

        // A strobed result: compare with the oldest outcome due
        function void check_result(logic [1:0] st, logic fnd, logic [OCC_W-1:0] occ);
            outcome_t e;
            if (awaited.size() == 0)
            begin
                $error("result with no request pending: status %0d found %0d occupancy %0d",
                       st, fnd, occ);
                mismatches++;
                return;
            end
            e = awaited[0];
            awaited.delete(0);
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                mismatches++;
            end
            if (fnd !== e.found)
            begin
                $error("found: expected %0d, actual %0d", e.found, fnd);
                mismatches++;
            end
            if (occ !== e.occupancy)
            begin
                $error("occupancy: expected %0d, actual %0d", e.occupancy, occ);
                mismatches++;
            end
        endfunction

        // Some value currently held; count must be nonzero
        function logic [31:0] live_value();
            return slots[front + 6'($urandom_range(count - 1))];
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic [2:0]               command;
    logic signed [31:0]       value;
    logic                     busy;
    logic                     done;
    logic [1:0]               status;
    logic                     found;
    logic [OCC_W-1:0]         occupancy;

    deque_tracker tracker;

    bounded_deque_with_search #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .value     (value),
        .busy      (busy),
        .done      (done),
        .status    (status),
        .found     (found),
        .occupancy (occupancy)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Result monitor: done is a one-cycle strobe
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_result(status, found, occupancy);
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Issue one request, with random idle cycles ahead of it
    task automatic issue(input logic [2:0] cmd, input logic [31:0] val, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        value   <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_request(cmd, val);
    endtask

    // Values: small signed pool for repeats, full-range, and the extremes
    function automatic logic [31:0] draw_value();
        int unsigned pick;
        logic [31:0] s;
        pick = $urandom_range(9);
        if (pick < 4)
        begin
            s = 32'($urandom_range(15));
            if ($urandom_range(1)) s = -s;
        end
        else if (pick < 8)
            s = $urandom;
        else
        begin
            case ($urandom_range(3))
                0:       s = 32'h8000_0000;
                1:       s = 32'h7FFF_FFFF;
                2:       s = 32'h0000_0000;
                default: s = 32'hFFFF_FFFF;
            endcase
        end
        return s;
    endfunction

    // Random traffic in segments that lean toward filling, draining or neither
    task automatic run_random(input int n_items, input int idle_pct);
        mix_t        mix;
        int          seg_left;
        int          push_w;
        int          pop_w;
        int          roll;
        int          issued;
        logic [2:0]  cmd;
        logic [31:0] val;
        seg_left = 0;
        issued   = 0;
        mix      = MIX_EVEN;
        while (issued < n_items)
        begin
            if (seg_left == 0)
            begin
                mix      = mix_t'($urandom_range(2));
                seg_left = $urandom_range(20, 150);
            end
            seg_left--;
            case (mix)
                MIX_FILL:  begin push_w = 70; pop_w = 12; end
                MIX_DRAIN: begin push_w = 12; pop_w = 70; end
                default:   begin push_w = 35; pop_w = 35; end
            endcase
            roll = $urandom_range(99);
            val  = draw_value();
            if (roll < push_w)
                cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            else if (roll < push_w + pop_w)
                cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
            else if (roll < 97)
            begin
                cmd = CMD_CHECK;
                // on a nonempty deque, half the checks look for something actually held
                if (tracker.count > 0 && $urandom_range(1))
                    val = tracker.live_value();
            end
            else
                cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            issue(cmd, val, idle_pct);
            if (cmd < CMD_SPARE_FIRST)
                issued++;
        end
    endtask

    // Main sequence
    initial
    begin
        int k;
        tracker = new();
        rst_n   <= 1'b0;
        start   <= 1'b0;
        command <= CMD_PUSH_FRONT;
        value   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-queue cases and spare codes
        issue(CMD_POP_FRONT, 32'h0000_0000, 0);
        issue(CMD_POP_BACK, 32'hFFFF_FFFF, 0);
        issue(CMD_CHECK, 32'h0000_0000, 0);
        issue(CMD_SPARE_FIRST, 32'h1234_5678, 0);
        issue(CMD_SPARE_MID, 32'h8000_0000, 0);
        issue(CMD_SPARE_LAST, 32'h7FFF_FFFF, 0);
        // Extremes at both ends; push front from slot 0 wraps the ring
        issue(CMD_PUSH_BACK, 32'h7FFF_FFFF, 0);
        issue(CMD_PUSH_FRONT, 32'h8000_0000, 0);
        issue(CMD_PUSH_BACK, 32'h0000_0000, 0);
        issue(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 0);
        // Hits and near misses (one bit off)
        issue(CMD_CHECK, 32'h8000_0000, 0);
        issue(CMD_CHECK, 32'h7FFF_FFFF, 0);
        issue(CMD_CHECK, 32'h0000_0001, 0);
        issue(CMD_CHECK, 32'hFFFF_FFFE, 0);
        issue(CMD_SPARE_LAST, 32'h0000_0000, 0);
        // Pop each end, then confirm the removed values are gone and a kept one is found
        issue(CMD_POP_FRONT, 32'h0000_0000, 0);
        issue(CMD_CHECK, 32'hFFFF_FFFF, 0);
        issue(CMD_POP_BACK, 32'h0000_0000, 0);
        issue(CMD_CHECK, 32'h0000_0000, 0);
        issue(CMD_CHECK, 32'h7FFF_FFFF, 0);
        issue(CMD_POP_FRONT, 32'h0000_0000, 0);
        issue(CMD_POP_BACK, 32'h0000_0000, 0);
        issue(CMD_POP_BACK, 32'h0000_0000, 0);

        // Random phases: light sender idling, heavy idling, none
        run_random(400, 11);
        run_random(400, 57);
        run_random(400, 0);
        start <= 1'b0;

        // Drain outstanding results, then watch for strays
        for (k = 0; k < 8 * DEPTH && tracker.awaited.size() > 0; k++)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        if (tracker.awaited.size() > 0)
        begin
            $error("%0d results never arrived", tracker.awaited.size());
            tracker.mismatches++;
        end

        if (tracker.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
